// ===== hw/rtl/quoted_item_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// quoted_item_tokenizer_defines
// assertion macros for the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef QUOTED_ITEM_TOKENIZER_DEFINES_SVH
`define QUOTED_ITEM_TOKENIZER_DEFINES_SVH

// checked only while out of reset
`define QIT_ASSERT_ON(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// checked on every edge, reset included
`define QIT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

// ===== hw/rtl/qit_pkg.sv =====
// ----------------------------------------------------------------------------
// qit_pkg
// types and constants of the quoted item tokenizer
// ----------------------------------------------------------------------------
package qit_pkg;

  localparam int EOF_WORD_MAX = 8;
  localparam int QUEUE_DEPTH  = 4;  // power of two, pointers wrap naturally
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_SPLIT_MODE = 2'd0;
  localparam logic [1:0] CFG_DELIMITER  = 2'd1;
  localparam logic [1:0] CFG_EOF_LEN    = 2'd2;
  localparam logic [1:0] CFG_EOF_WORD   = 2'd3;

  // split modes
  localparam logic [1:0] MODE_WS  = 2'd0;
  localparam logic [1:0] MODE_NUL = 2'd1;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    logic       at_line_end;
    logic       logical_eof;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  split_mode;
    logic [7:0]  delimiter_byte;
    logic [3:0]  eof_word_length;
    logic [63:0] eof_word;
  } cfg_t;

  // one accepted byte's work: one or two results
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } cmd_t;

endpackage

// ===== hw/rtl/qit_front.sv =====
// ----------------------------------------------------------------------------
// qit_front
// scan state machine: classifies each byte and queues the results it causes
// ----------------------------------------------------------------------------
module qit_front (
  input  logic              clk,
  input  logic              rst_n,
  input  qit_pkg::cfg_t     cfg,
  input  logic              in_accept,
  input  qit_pkg::in_item_t in_item,
  output logic              cmd_push,
  output qit_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ITEM = 3'd1;
  localparam logic [2:0] ST_ESC  = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_DQ   = 3'd4;
  localparam logic [2:0] ST_STOP = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  logic [2:0] state_r, state_nxt;
  logic [3:0] match_count_r, match_count_nxt;
  logic       match_alive_r, match_alive_nxt;

  function automatic qit_pkg::out_item_t data_item(input logic [7:0] c);
    qit_pkg::out_item_t r;
    r             = '0;
    r.result_kind = qit_pkg::KIND_DATA;
    r.out_byte    = c;
    return r;
  endfunction

  function automatic qit_pkg::out_item_t end_item(input logic eol, input logic leof);
    qit_pkg::out_item_t r;
    r             = '0;
    r.result_kind = qit_pkg::KIND_END;
    r.at_line_end = eol;
    r.logical_eof = leof;
    return r;
  endfunction

  always_comb begin
    logic [2:0] st;
    logic [3:0] mc;
    logic       al;
    logic [7:0] c;
    logic       eoi;
    logic [7:0] delim;
    logic [1:0] cnt;
    logic       hit;
    logic       is_sp;
    logic [7:0] want;

    c     = in_item.in_byte;
    eoi   = in_item.end_of_input;
    st    = state_r;
    mc    = match_count_r;
    al    = match_alive_r;
    cnt   = 2'd0;
    hit   = 1'b0;
    want  = '0;
    is_sp = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    delim = (cfg.split_mode == qit_pkg::MODE_NUL) ? 8'h00 : cfg.delimiter_byte;
    cmd   = '0;
    state_nxt = state_r;

    if (state_r == ST_STOP) begin
      if (eoi) state_nxt = ST_IDLE;
    end else if (cfg.split_mode != qit_pkg::MODE_WS) begin
      // delimited modes: any non-idle state is inside an item
      if (eoi) begin
        if (state_r != ST_IDLE) begin
          cmd.first = end_item(1'b1, 1'b0);
          cnt       = 2'd1;
        end
        state_nxt = ST_IDLE;
      end else if (c == delim) begin
        cmd.first = end_item(1'b1, 1'b0);
        cnt       = 2'd1;
        state_nxt = ST_IDLE;
      end else begin
        cmd.first = data_item(c);
        cnt       = 2'd1;
        state_nxt = ST_ITEM;
      end
    end else begin
      // a non-space byte at idle opens an item and is handled as inside it
      if (st == ST_IDLE && !eoi && !is_sp) begin
        st = ST_ITEM;
        mc = 4'd0;
        al = 1'b1;
        state_nxt = ST_ITEM;
      end
      // escaped byte or quoted text: the tracked byte is the data byte
      want = (st == ST_ESC && eoi) ? CH_BSL : c;
      unique case (st)
        ST_IDLE: begin
        end
        ST_ITEM: begin
          priority if (eoi || is_sp) begin
            cnt = 2'd1;
          end else if (c == CH_BSL) begin
            state_nxt = ST_ESC;
          end else if (c == CH_SQ) begin
            state_nxt = ST_SQ;
          end else if (c == CH_DQ) begin
            state_nxt = ST_DQ;
          end else begin
            cmd.first = data_item(c);
            cnt       = 2'd1;
          end
        end
        ST_ESC: begin
          cmd.first = data_item(want);
          cnt       = eoi ? 2'd2 : 2'd1;
          state_nxt = ST_ITEM;
        end
        ST_SQ, ST_DQ: begin
          priority if (eoi) begin
            cnt = 2'd1;
          end else if ((st == ST_SQ && c == CH_SQ) || (st == ST_DQ && c == CH_DQ)) begin
            state_nxt = ST_ITEM;
          end else begin
            cmd.first = data_item(c);
            cnt       = 2'd1;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase

      // prefix tracking against the end word on every emitted data byte
      if (cnt != 2'd0 && !(st == ST_ITEM && (eoi || is_sp))
          && !(st != ST_ESC && eoi) && al) begin
        if (mc < cfg.eof_word_length && !mc[3]
            && cfg.eof_word[{mc[2:0], 3'b000} +: 8] == want) begin
          mc = mc + 4'd1;
        end else begin
          al = 1'b0;
        end
      end

      // item close: plain end, end of input, or escape at end of input
      if ((st == ST_ITEM && (eoi || is_sp)) || ((st == ST_SQ || st == ST_DQ) && eoi)
          || (st == ST_ESC && eoi)) begin
        hit = al && (cfg.eof_word_length != 4'd0)
              && (cfg.eof_word_length <= 4'(qit_pkg::EOF_WORD_MAX))
              && (mc == cfg.eof_word_length);
        if (st == ST_ESC) begin
          cmd.second = end_item(1'b0, hit);
        end else begin
          cmd.first = end_item(!hit && !eoi && c == CH_LF, hit);
        end
        state_nxt = hit ? ST_STOP : ST_IDLE;
      end
      if (eoi) state_nxt = ST_IDLE;
    end

    cmd.two         = cnt[1];
    cmd_push        = in_accept && (cnt != 2'd0);
    match_count_nxt = mc;
    match_alive_nxt = al;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      match_count_r <= 4'd0;
      match_alive_r <= 1'b1;
    end else if (in_accept) begin
      state_r       <= state_nxt;
      match_count_r <= match_count_nxt;
      match_alive_r <= match_alive_nxt;
    end
  end

endmodule

// ===== hw/rtl/qit_fifo.sv =====
// ----------------------------------------------------------------------------
// qit_fifo
// short command queue between scanner and result sequencer
// ----------------------------------------------------------------------------
module qit_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qit_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output qit_pkg::cmd_t pop_data,
  output logic          empty
);

  qit_pkg::cmd_t                  mem_r [qit_pkg::QUEUE_DEPTH];
  logic [qit_pkg::QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [qit_pkg::QUEUE_CW-1:0]   count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full     = (count_r == qit_pkg::QUEUE_CW'(qit_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/qit_back.sv =====
// ----------------------------------------------------------------------------
// qit_back
// result sequencer: holds one command and hands out its results in order
// ----------------------------------------------------------------------------
module qit_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  qit_pkg::cmd_t      cmd_data,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output qit_pkg::out_item_t out_item
);

  qit_pkg::cmd_t cur_r;
  logic          valid_r, valid_nxt;
  logic          phase_r, phase_nxt;
  logic          taken, done;

  assign empty    = !valid_r;
  assign out_item = phase_r ? cur_r.second : cur_r.first;
  assign taken    = valid_r && pop;
  assign done     = taken && (!cur_r.two || phase_r);
  assign cmd_pop  = !cmd_empty && (!valid_r || done);

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    priority if (cmd_pop) begin
      valid_nxt = 1'b1;
      phase_nxt = 1'b0;
    end else if (done) begin
      valid_nxt = 1'b0;
      phase_nxt = 1'b0;
    end else if (taken) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_r <= cmd_data;
  end

endmodule

// ===== hw/rtl/quoted_item_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_item_tokenizer
// splits a byte stream into items, one request per byte, results as a queue
// ----------------------------------------------------------------------------
// a result passes the command queue and then the output register before it reaches the out ports
// throughput: one byte per cycle while the command queue has room; the scanner state machine
//   decides each byte, the result sequencer hands out one result per cycle while pop is held
// a backslash closed by end of input gives two results
// reset (synchronous, rst_n low): scanner idle, queues empty, registers default
`include "quoted_item_tokenizer_defines.svh"

module quoted_item_tokenizer (
  input  logic               clk,
  input  logic               rst_n,
  // byte requests
  input  logic               push,
  output logic               full,
  input  qit_pkg::in_item_t  in_item,
  // results
  output logic               empty,
  input  logic               pop,
  output qit_pkg::out_item_t out_item,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  qit_pkg::cfg_t cfg_r;
  qit_pkg::cmd_t cmd, cmd_data;
  logic          in_accept;
  logic          cmd_push, cmd_pop, cmd_empty;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.split_mode      <= qit_pkg::MODE_WS;
      cfg_r.delimiter_byte  <= 8'h0A;
      cfg_r.eof_word_length <= 4'd0;
      cfg_r.eof_word        <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qit_pkg::CFG_SPLIT_MODE: cfg_r.split_mode      <= cfg_data[1:0];
        qit_pkg::CFG_DELIMITER:  cfg_r.delimiter_byte  <= cfg_data[7:0];
        qit_pkg::CFG_EOF_LEN:    cfg_r.eof_word_length <= cfg_data[3:0];
        qit_pkg::CFG_EOF_WORD:   cfg_r.eof_word        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a byte is taken whenever the command queue has room
  assign in_accept = push && !full;

  // front: scanner state machine, one byte per cycle while the command queue has room
  qit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_accept (in_accept),
    .in_item   (in_item),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  // queue between scanner and sequencer; bytes with no result skip it
  qit_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_data),
    .empty     (cmd_empty)
  );

  // back: output register, refilled in the cycle its last result is taken if a command waits
  qit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  // ---- assertions ----
  // after reset nothing is pending on either side
  `QIT_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (empty && !full), "queues not clear after reset")
  // an end marker never carries a byte
  `QIT_ASSERT_ON(a_end_no_byte, (!empty && out_item.result_kind == qit_pkg::KIND_END) |-> (out_item.out_byte == 8'h00), "end marker with byte")
  // a data byte carries no end flags
  `QIT_ASSERT_ON(a_data_no_flags, (!empty && out_item.result_kind == qit_pkg::KIND_DATA) |-> (!out_item.at_line_end && !out_item.logical_eof), "data byte with flags")
  // logical end and line end never come together
  `QIT_ASSERT_ON(a_eof_not_eol, !empty |-> !(out_item.logical_eof && out_item.at_line_end), "logical end with line end")

endmodule
